// ===== rtl/core/csv_record_field_tokenizer_assert.svh =====
// Assertion macros for the CSV tokenizer core.
// Included by modules that check their own state; they rely on clk and rst_n in scope.
`ifndef CSV_RECORD_FIELD_TOKENIZER_ASSERT_SVH
`define CSV_RECORD_FIELD_TOKENIZER_ASSERT_SVH

// Same-cycle implication, checked only out of reset.
`define CRFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only out of reset.
`define CRFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/crft_pkg.sv =====
// Shared types, constants and helpers for the CSV record/field tokenizer.
// No dependencies; imported by csv_record_field_tokenizer.
`default_nettype none

package crft_pkg;

    localparam int LINE_BITS  = 32;
    localparam int FIELD_BITS = 8;

    localparam logic [LINE_BITS-1:0]  LINE_MAX  = {LINE_BITS{1'b1}};
    localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_NUL = 8'd0;

    localparam logic [7:0] DELIM_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;

    // Register map, indexed by word address
    localparam logic REG_DELIM = 1'b0;
    localparam logic REG_QUOTE = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2,
        KIND_ERROR      = 2'd3
    } kind_t;

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] cnt);
        return (cnt == LINE_MAX) ? cnt : cnt + LINE_BITS'(1);
    endfunction

    function automatic logic [7:0] field_sat(input logic [FIELD_BITS-1:0] cnt);
        logic [15:0] w;
        w = 16'(cnt);
        return (w > 16'd255) ? 8'hFF : w[7:0];
    endfunction

    function automatic logic [31:0] line_sat(input logic [LINE_BITS-1:0] cnt);
        logic [63:0] w;
        w = 64'(cnt);
        return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/csv_record_field_tokenizer.sv =====
// CSV record/field tokenizer: one text byte per word in, at most one token word out.
// Depends on crft_pkg and csv_record_field_tokenizer_assert.svh.
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+------------------------------------
//   input     | in        | in_valid / in_ready    | func, data_byte
//   output    | out       | out_valid / out_ready  | kind, out_byte, field_number,
//             |           |                        | line_count
//   config    | in        | APB psel/penable/...   | delimiter (0x0), quote (0x4)
//
// One input word per cycle while in_ready is high. Each word is parsed in the cycle it is accepted and
// its token, if any, lands in the output register at that edge.
// in_ready stays high while the output register is empty or being drained, so a
// stall downstream backs up the input after one token word. Reset (rst_n low, async)
// clears all parse state, the error latch and the output valid; the delimiter
// and quote registers return to comma and double quote.
`default_nettype none
`include "csv_record_field_tokenizer_assert.svh"

module csv_record_field_tokenizer
    import crft_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [7:0]  data_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       out_byte,
    output logic [7:0]       field_number,
    output logic [31:0]      line_count,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0] delim_reg;
    logic [7:0] quote_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= DELIM_RESET;
            quote_reg <= QUOTE_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_DELIM: delim_reg <= pwdata[7:0];
                REG_QUOTE: quote_reg <= pwdata[7:0];
                default:   delim_reg <= delim_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DELIM: prdata = {24'd0, delim_reg};
            REG_QUOTE: prdata = {24'd0, quote_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Parse state
    // ------------------------------------------------------------------
    logic                  inq_reg,      inq_next;
    logic                  qpend_reg,    qpend_next;
    logic                  after_cr_reg, after_cr_next;
    logic                  nonempty_reg, nonempty_next;
    logic [LINE_BITS-1:0]  line_reg,     line_next;
    logic [FIELD_BITS-1:0] field_reg,    field_next;
    logic                  err_reg,      err_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    kind_t       kind_reg,      kind_next;
    logic [7:0]  byte_reg,      byte_next;
    logic [7:0]  fnum_reg,      fnum_next;
    logic [31:0] lcnt_reg,      lcnt_next;

    logic in_acc;
    logic emit;
    logic go_unq;
    kind_t emit_kind;
    logic [7:0] emit_byte;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_acc   = in_valid && in_ready;

    always_comb
    begin
        inq_next      = inq_reg;
        qpend_next    = qpend_reg;
        after_cr_next = after_cr_reg;
        nonempty_next = nonempty_reg;
        line_next     = line_reg;
        field_next    = field_reg;
        err_next      = err_reg;
        emit          = 1'b0;
        go_unq        = 1'b0;
        emit_kind     = KIND_BYTE;
        emit_byte     = 8'd0;

        if (in_acc)
        begin
            if (err_reg)
            begin
                // sticky error: report and change nothing
                emit      = 1'b1;
                emit_kind = KIND_ERROR;
            end
            else if (func)
            begin
                // end of text: flush a pending record, then restart at line 1
                if (nonempty_reg)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_RECORD_END;
                end
                inq_next      = 1'b0;
                qpend_next    = 1'b0;
                after_cr_next = 1'b0;
                nonempty_next = 1'b0;
                line_next     = '0;
                field_next    = '0;
            end
            else if (data_byte == CH_NUL)
            begin
                err_next  = 1'b1;
                emit      = 1'b1;
                emit_kind = KIND_ERROR;
            end
            else
            begin
                after_cr_next = 1'b0;
                if (qpend_reg)
                begin
                    // doubled quote is a literal; anything else closes the quoting
                    qpend_next = 1'b0;
                    if (data_byte == quote_reg)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_BYTE;
                        emit_byte = data_byte;
                    end
                    else
                    begin
                        inq_next = 1'b0;
                        go_unq   = 1'b1;
                    end
                end
                else if (inq_reg)
                begin
                    nonempty_next = 1'b1;
                    if (data_byte == quote_reg)
                    begin
                        qpend_next = 1'b1;
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_BYTE;
                        emit_byte = data_byte;
                    end
                end
                else if (after_cr_reg && data_byte == CH_LF && data_byte != quote_reg)
                begin
                    // swallow the LF of a CRLF pair
                    go_unq = 1'b0;
                end
                else
                begin
                    go_unq = 1'b1;
                end

                if (go_unq)
                begin
                    if (data_byte == quote_reg)
                    begin
                        inq_next      = 1'b1;
                        nonempty_next = 1'b1;
                    end
                    else if (data_byte == CH_CR || data_byte == CH_LF)
                    begin
                        if (nonempty_reg)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_RECORD_END;
                        end
                        line_next     = line_inc(line_reg);
                        field_next    = '0;
                        nonempty_next = 1'b0;
                        after_cr_next = (data_byte == CH_CR);
                    end
                    else if (data_byte == delim_reg)
                    begin
                        nonempty_next = 1'b1;
                        emit          = 1'b1;
                        emit_kind     = KIND_FIELD_END;
                        if (field_reg != FIELD_MAX)
                        begin
                            field_next = field_reg + FIELD_BITS'(1);
                        end
                    end
                    else
                    begin
                        nonempty_next = 1'b1;
                        emit          = 1'b1;
                        emit_kind     = KIND_BYTE;
                        emit_byte     = data_byte;
                    end
                end
            end
        end
    end

    // Load the output register whenever it is free; hold it while stalled.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        fnum_next      = fnum_reg;
        lcnt_next      = lcnt_reg;
        if (in_ready)
        begin
            out_valid_next = in_acc && emit;
            kind_next      = emit_kind;
            byte_next      = emit_byte;
            fnum_next      = field_sat(field_reg);
            lcnt_next      = line_sat(line_inc(line_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inq_reg       <= 1'b0;
            qpend_reg     <= 1'b0;
            after_cr_reg  <= 1'b0;
            nonempty_reg  <= 1'b0;
            line_reg      <= '0;
            field_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            inq_reg       <= inq_next;
            qpend_reg     <= qpend_next;
            after_cr_reg  <= after_cr_next;
            nonempty_reg  <= nonempty_next;
            line_reg      <= line_next;
            field_reg     <= field_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        fnum_reg <= fnum_next;
        lcnt_reg <= lcnt_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign out_byte     = byte_reg;
    assign field_number = fnum_reg;
    assign line_count   = lcnt_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CRFT_ASSERT_NEXT(a_err_sticky, err_reg, err_reg, "error latch cleared without reset")
    `CRFT_ASSERT_NOW(a_qpend_in_quote, qpend_reg, inq_reg, "pending quote outside quoted text")
    `CRFT_ASSERT_NOW(a_cr_clean, after_cr_reg, !inq_reg && !nonempty_reg,
        "CR state with open quote or non-empty line")
    `CRFT_ASSERT_NOW(a_field_line, field_reg != '0, nonempty_reg,
        "field index advanced on an empty line")
    `CRFT_ASSERT_NEXT(a_err_report, in_acc && err_reg, out_valid && kind == KIND_ERROR,
        "word after error not reported as error")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for csv_record_field_tokenizer: directed and random CSV text,
// each token word checked against a typed expectation or a tokenizer predictor kept in step with the block.
// Depends on crft_pkg and the RTL of csv_record_field_tokenizer.

module tb;
    import crft_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int TIMEOUT_CYCLES = 300_000;
    localparam int LONG_HOLD      = 150;   // cycles of downstream back-pressure
    localparam int PHASE_WORDS    = 155;   // least number of random text words per register setting
    localparam int WIDE_FIELDS    = 262;   // drives the field index into saturation

    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_END  = 1'b1;

    // One input word: function bit and text byte.
    typedef struct packed {
        logic       f;
        logic [7:0] c;
    } word_t;

    // One token word as the block presents it.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  content;
        logic [7:0]  field_idx;
        logic [31:0] line_no;
    } token_t;

    // Directed row: an expectation is typed in only where `typed` is set.
    typedef struct {
        word_t  w;
        bit     typed;
        bit     gives;
        token_t tok;
    } dir_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        func      = FUNC_DATA;
    logic [7:0]  data_byte = 8'h00;
    logic        out_ready = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;

    logic        in_ready;
    logic        out_valid;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic [7:0]  field_number;
    logic [31:0] line_count;
    logic [31:0] prdata;
    logic        pready;

    csv_record_field_tokenizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .out_byte     (out_byte),
        .field_number (field_number),
        .line_count   (line_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 0;
    end

    // Tokenizer predictor state, mirrored from the block's parse state.
    logic        st_quoted;
    logic        st_qpend;
    logic        st_after_cr;
    logic        st_busy;      // current line holds at least one byte
    logic        st_error;
    logic [31:0] st_lines;
    logic [7:0]  st_field;
    logic [7:0]  cfg_delim;
    logic [7:0]  cfg_quote;

    token_t   pending_tokens[$];   // token words still owed by the block
    word_t    text_words[$];       // text queued for the current phase
    dir_row_t dir_rows[$];

    int words_sent  = 0;
    int tokens_seen = 0;
    int fail_count  = 0;
    bit idle_on       = 1'b1;
    bit send_calm     = 1'b0;
    bit recv_calm     = 1'b0;
    bit long_hold_req = 1'b0;

    function automatic logic [31:0] next_line();
        if (&st_lines)
            return st_lines;
        return st_lines + 32'd1;
    endfunction

    // Tokens carry the current field index and the number of the current line.
    function automatic token_t make_token(kind_t k, logic [7:0] b);
        token_t t;
        t.kind      = k;
        t.content   = b;
        t.field_idx = st_field;
        t.line_no   = next_line();
        return t;
    endfunction

    task automatic clear_parse();
        st_quoted   = 1'b0;
        st_qpend    = 1'b0;
        st_after_cr = 1'b0;
        st_busy     = 1'b0;
        st_lines    = '0;
        st_field    = '0;
    endtask

    // Byte outside quotes: quote first, then CR/LF, then the delimiter.
    task automatic plain_byte(input logic [7:0] c, output bit gives, output token_t t);
        gives = 1'b0;
        t     = '0;
        if (c == cfg_quote)
        begin
            st_quoted = 1'b1;
            st_busy   = 1'b1;
        end
        else if (c == CH_CR || c == CH_LF)
        begin
            if (st_busy)
            begin
                gives = 1'b1;
                t     = make_token(KIND_RECORD_END, 8'h00);
            end
            st_lines    = next_line();
            st_field    = '0;
            st_busy     = 1'b0;
            st_after_cr = (c == CH_CR);
        end
        else
        begin
            st_busy = 1'b1;
            gives   = 1'b1;
            if (c == cfg_delim)
            begin
                t = make_token(KIND_FIELD_END, 8'h00);
                if (st_field != FIELD_MAX)
                    st_field = st_field + 8'd1;
            end
            else
                t = make_token(KIND_BYTE, c);
        end
    endtask

    // Advance the predictor by one accepted word; report the token it owes, if any.
    task automatic tokenize(input word_t w, output bit gives, output token_t t);
        logic was_cr;
        gives  = 1'b0;
        t      = '0;
        was_cr = st_after_cr;
        if (st_error)
        begin
            gives = 1'b1;
            t     = make_token(KIND_ERROR, 8'h00);
        end
        else if (w.f == FUNC_END)
        begin
            if (st_busy)
            begin
                gives = 1'b1;
                t     = make_token(KIND_RECORD_END, 8'h00);
            end
            clear_parse();
        end
        else if (w.c == CH_NUL)
        begin
            st_error = 1'b1;
            gives    = 1'b1;
            t        = make_token(KIND_ERROR, 8'h00);
        end
        else
        begin
            st_after_cr = 1'b0;
            if (st_qpend)
            begin
                st_qpend = 1'b0;
                if (w.c == cfg_quote)
                begin
                    gives = 1'b1;
                    t     = make_token(KIND_BYTE, w.c);
                end
                else
                begin
                    st_quoted = 1'b0;
                    plain_byte(w.c, gives, t);
                end
            end
            else if (st_quoted)
            begin
                st_busy = 1'b1;
                if (w.c == cfg_quote)
                    st_qpend = 1'b1;
                else
                begin
                    gives = 1'b1;
                    t     = make_token(KIND_BYTE, w.c);
                end
            end
            else if (!(was_cr && w.c == CH_LF && w.c != cfg_quote))
                plain_byte(w.c, gives, t);
        end
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Drive one word, with an optional idle burst first, and hold it until accepted.
    task automatic send_word(input word_t w, output bit gives, output token_t t);
        if (idle_on && !send_calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        func      <= w.f;
        data_byte <= w.c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tokenize(w, gives, t);
        words_sent++;
        // re-roll now and then so long runs without sender gaps show up too
        if (words_sent % 48 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic offer(input word_t w);
        bit     gives;
        token_t t;
        send_word(w, gives, t);
        if (gives)
            pending_tokens.push_back(t);
    endtask

    // Let the block run dry: all owed tokens out, then idle clocks so that a word
    // that produces nothing is through as well.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write a register, then read it back over the same address.
    task automatic cfg_write(input logic reg_sel, input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (reg_sel == REG_DELIM)
            cfg_delim = value;
        else
            cfg_quote = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'h0, value})
            report_mismatch($sformatf("readback reg %0d exp %h got %h",
                                      reg_sel, {24'h0, value}, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == cfg_delim || c == cfg_quote || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    task automatic add_word(input logic f, input logic [7:0] c);
        text_words.push_back({f, c});
    endtask

    // One CSV record with random content: plain and quoted fields, embedded
    // delimiters, newlines and doubled quotes, and a random line ending.
    task automatic build_record();
        int nf;
        int len;
        nf = $urandom_range(0, 6);
        for (int i = 0; i < nf; i++)
        begin
            if (i > 0)
                add_word(FUNC_DATA, cfg_delim);
            len = $urandom_range(0, 5);
            if ($urandom_range(0, 2) == 0)
            begin
                add_word(FUNC_DATA, cfg_quote);
                for (int j = 0; j < len; j++)
                begin
                    case ($urandom_range(0, 7))
                        0: add_word(FUNC_DATA, cfg_delim);
                        1: add_word(FUNC_DATA, CH_CR);
                        2: add_word(FUNC_DATA, CH_LF);
                        3:
                        begin
                            add_word(FUNC_DATA, cfg_quote);
                            add_word(FUNC_DATA, cfg_quote);
                        end
                        default: add_word(FUNC_DATA, pick_plain());
                    endcase
                end
                add_word(FUNC_DATA, cfg_quote);
            end
            else
            begin
                for (int j = 0; j < len; j++)
                    add_word(FUNC_DATA, pick_plain());
            end
        end
        case ($urandom_range(0, 7))
            0, 1: add_word(FUNC_DATA, CH_CR);
            2, 3: add_word(FUNC_DATA, CH_LF);
            4, 5:
            begin
                add_word(FUNC_DATA, CH_CR);
                add_word(FUNC_DATA, CH_LF);
            end
            6: add_word(FUNC_END, 8'($urandom_range(0, 255)));
            default:
            begin
                add_word(FUNC_DATA, CH_LF);
                add_word(FUNC_DATA, CH_LF);
            end
        endcase
    endtask

    // Unstructured bytes; end-of-input words carry any byte, zero included.
    task automatic add_noise();
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(0, 15) == 0)
                add_word(FUNC_END, 8'($urandom_range(0, 255)));
            else
                add_word(FUNC_DATA, 8'($urandom_range(1, 255)));
        end
    endtask

    // One register setting: wait for idle, program, then stream random text.
    task automatic run_phase(input logic [7:0] delim, input logic [7:0] quote,
                             input bit wide, input bit squeeze);
        int target;
        drain();
        cfg_write(REG_DELIM, delim);
        cfg_write(REG_QUOTE, quote);
        text_words.delete();
        target = PHASE_WORDS;
        if (wide)
        begin
            // one record wider than the field index can count
            add_word(FUNC_DATA, pick_plain());
            repeat (WIDE_FIELDS) add_word(FUNC_DATA, cfg_delim);
            add_word(FUNC_DATA, pick_plain());
            add_word(FUNC_DATA, CH_LF);
            target += WIDE_FIELDS + 3;
        end
        while (text_words.size() < target)
        begin
            if ($urandom_range(0, 9) == 0)
                add_noise();
            else
                build_record();
        end
        if (squeeze)
            long_hold_req = 1'b1;
        foreach (text_words[i])
            offer(text_words[i]);
    endtask

    task automatic row_pred(input logic f, input logic [7:0] c);
        dir_row_t r;
        r.w     = {f, c};
        r.typed = 1'b0;
        r.gives = 1'b0;
        r.tok   = '0;
        dir_rows.push_back(r);
    endtask

    task automatic row_typed(input logic f, input logic [7:0] c, input bit gives,
                             input kind_t k, input logic [7:0] content,
                             input logic [7:0] fld, input logic [31:0] ln);
        dir_row_t r;
        r.w             = {f, c};
        r.typed         = 1'b1;
        r.gives         = gives;
        r.tok.kind      = k;
        r.tok.content   = content;
        r.tok.field_idx = fld;
        r.tok.line_no   = ln;
        dir_rows.push_back(r);
    endtask

    // Receiver: random ready bursts, one long hold-off on request, none at the end.
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles % 40 == 0)
                recv_calm = ($urandom_range(0, 3) == 0);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++)
                    @(posedge clk);
            end
            else if (idle_on && !recv_calm && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Scoreboard: each token word against the oldest owed token, field by field.
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n && out_valid && out_ready)
        begin
            tokens_seen++;
            if (pending_tokens.size() == 0)
                report_mismatch($sformatf("unexpected token kind %0d byte %h field %0d line %0d",
                                          kind, out_byte, field_number, line_count));
            else
            begin
                want = pending_tokens.pop_front();
                if (want.kind !== kind || want.content !== out_byte
                    || want.field_idx !== field_number || want.line_no !== line_count)
                    report_mismatch($sformatf(
                        "exp %s/%h/%0d/%0d got %0d/%h/%0d/%0d", want.kind.name(),
                        want.content, want.field_idx, want.line_no,
                        kind, out_byte, field_number, line_count));
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("TIMEOUT: %0d tokens still owed", pending_tokens.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        bit     gives;
        token_t t;
        int     guard;

        cfg_delim = DELIM_RESET;
        cfg_quote = QUOTE_RESET;
        st_error  = 1'b0;
        clear_parse();

        // Directed text under the reset settings (comma, double quote).
        row_typed(FUNC_DATA, 8'h61, 1, KIND_BYTE,       8'h61, 8'd0, 32'd1);
        row_typed(FUNC_DATA, 8'hFF, 1, KIND_BYTE,       8'hFF, 8'd0, 32'd1);
        row_typed(FUNC_DATA, 8'h2C, 1, KIND_FIELD_END,  8'h00, 8'd0, 32'd1);
        row_typed(FUNC_DATA, 8'h01, 1, KIND_BYTE,       8'h01, 8'd1, 32'd1);
        row_typed(FUNC_DATA, 8'h22, 0, KIND_BYTE,       8'h00, 8'd0, 32'd0);
        row_pred (FUNC_DATA, 8'h2C);        // delimiter inside quotes is data
        row_pred (FUNC_DATA, CH_CR);        // newlines inside quotes are data
        row_pred (FUNC_DATA, CH_LF);
        row_pred (FUNC_DATA, 8'h22);
        row_pred (FUNC_DATA, 8'h22);        // doubled quote: one literal quote
        row_pred (FUNC_DATA, 8'h22);
        row_pred (FUNC_DATA, 8'h62);        // closes quoting, then plain byte
        row_typed(FUNC_DATA, CH_CR, 1, KIND_RECORD_END, 8'h00, 8'd1, 32'd1);
        row_typed(FUNC_DATA, CH_LF, 0, KIND_BYTE,       8'h00, 8'd0, 32'd0);
        row_typed(FUNC_DATA, CH_LF, 0, KIND_BYTE,       8'h00, 8'd0, 32'd0);
        row_typed(FUNC_DATA, 8'h78, 1, KIND_BYTE,       8'h78, 8'd0, 32'd3);
        row_pred (FUNC_DATA, 8'h22);        // quote in mid field opens quoting
        row_pred (FUNC_DATA, 8'h22);
        row_pred (FUNC_DATA, CH_CR);        // pending quote closed by CR
        row_pred (FUNC_DATA, 8'h63);
        row_pred (FUNC_END,  8'h5A);
        row_typed(FUNC_END,  8'h00, 0, KIND_BYTE,       8'h00, 8'd0, 32'd0);
        row_typed(FUNC_DATA, 8'h64, 1, KIND_BYTE,       8'h64, 8'd0, 32'd1);
        row_pred (FUNC_DATA, 8'h22);
        row_typed(FUNC_END,  8'hA5, 1, KIND_RECORD_END, 8'h00, 8'd0, 32'd1);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i].w, gives, t);
            if (dir_rows[i].typed)
            begin
                if (dir_rows[i].gives)
                    pending_tokens.push_back(dir_rows[i].tok);
            end
            else if (gives)
                pending_tokens.push_back(t);
        end

        // Random text over several register settings; the first one also
        // carries the wide record and the long downstream stall.
        run_phase(DELIM_RESET, QUOTE_RESET, 1'b1, 1'b1);
        run_phase(8'h01, 8'hFF, 1'b0, 1'b0);
        run_phase(8'hFF, 8'h01, 1'b0, 1'b0);
        run_phase(8'h09, 8'h27, 1'b0, 1'b0);
        run_phase(8'h2C, 8'h2C, 1'b0, 1'b0);     // delimiter and quote collide
        run_phase(CH_CR, CH_LF, 1'b0, 1'b0);     // registers collide with newlines

        // Last stretch at full rate on both sides, ending in the sticky error.
        drain();
        idle_on = 1'b0;
        run_phase(8'h3B, 8'h22, 1'b0, 1'b0);
        offer({FUNC_DATA, CH_NUL});
        repeat (16) offer({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
        in_valid <= 1'b0;

        guard = 0;
        while (pending_tokens.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending_tokens.size() != 0)
        begin
            $display("%0d owed tokens never arrived", pending_tokens.size());
            fail_count += pending_tokens.size();
        end

        $display("Sent %0d text words under 7 delimiter/quote settings, %0d tokens checked,",
                 words_sent, tokens_seen);
        $display("including field index saturation, a long output stall and the sticky error.");
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
